FILE: hw/rtl/nfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash command sequencer package
// Shared widths, codes and the command descriptor passed from front to back.
// ----------------------------------------------------------------------------
package nfcs_pkg;

    localparam int OFF_W  = 21;
    localparam int DATA_W = 16;
    localparam int KIND_W = 2;
    localparam int STEP_W = 3;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int DQ6_BIT = 6;

    localparam logic [OFF_W-1:0]  ADDR_UNLOCK1 = 21'h05555;
    localparam logic [OFF_W-1:0]  ADDR_UNLOCK2 = 21'h02AAA;
    localparam logic [OFF_W-1:0]  ADDR_ZERO    = 21'h00000;
    localparam logic [DATA_W-1:0] CMD_UNLOCK1  = 16'h00AA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2  = 16'h0055;
    localparam logic [DATA_W-1:0] CMD_PROGRAM  = 16'h00A0;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 16'h0080;
    localparam logic [DATA_W-1:0] CMD_SECTOR   = 16'h0030;
    localparam logic [DATA_W-1:0] CMD_AUTOSEL  = 16'h0090;
    localparam logic [DATA_W-1:0] CMD_CFI      = 16'h0098;
    localparam logic [DATA_W-1:0] CMD_RESET    = 16'h00F0;

    typedef enum logic [2:0] {
        ACT_PROGRAM = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_AUTOSEL = 3'd2,
        ACT_CFI     = 3'd3,
        ACT_RESET   = 3'd4,
        ACT_READ    = 3'd5,
        ACT_REPLY   = 3'd6
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REFUSE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        SEQ_PROGRAM = 3'd0,
        SEQ_ERASE   = 3'd1,
        SEQ_AUTOSEL = 3'd2,
        SEQ_CFI     = 3'd3,
        SEQ_RESET   = 3'd4,
        SEQ_READ    = 3'd5,
        SEQ_DONE    = 3'd6,
        SEQ_REFUSE  = 3'd7
    } seq_t;

    typedef struct packed {
        seq_t              seq;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage : nfcs_pkg
`default_nettype wire

FILE: hw/rtl/nfcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash command sequencer front end
// Classifies each accepted item against the polling phase and emits one
// command descriptor per item.
// ----------------------------------------------------------------------------
module nfcs_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [2:0]                  action,
    input  wire logic [nfcs_pkg::OFF_W-1:0]  offset,
    input  wire logic [nfcs_pkg::DATA_W-1:0] data,
    output nfcs_pkg::cmd_t                   cmd
);
    import nfcs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FIRST = 3'b010,
        PH_POLL  = 3'b100
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               toggle_reg;
    logic               toggle_next;
    logic [OFF_W-1:0]   poll_off_reg;
    logic [OFF_W-1:0]   poll_off_next;
    logic               toggle_bit;

    assign toggle_bit = data[DQ6_BIT];

    always_comb
    begin
        phase_next    = phase_reg;
        toggle_next   = toggle_reg;
        poll_off_next = poll_off_reg;
        cmd.seq       = SEQ_REFUSE;
        cmd.offset    = '0;
        cmd.data      = '0;
        if (phase_reg != PH_IDLE)
        begin
            // While an operation is in flight only read replies are served; the rest are refused.
            if (action == ACT_REPLY)
            begin
                cmd.offset = poll_off_reg;
                priority if (phase_reg == PH_FIRST || toggle_bit != toggle_reg)
                begin
                    cmd.seq     = SEQ_READ;
                    toggle_next = toggle_bit;
                    phase_next  = PH_POLL;
                end
                else
                begin
                    cmd.seq    = SEQ_DONE;
                    phase_next = PH_IDLE;
                end
            end
        end
        else
        begin
            unique case (action)
                ACT_PROGRAM:
                begin
                    cmd.seq       = SEQ_PROGRAM;
                    cmd.offset    = offset;
                    cmd.data      = data;
                    poll_off_next = offset;
                    phase_next    = PH_FIRST;
                end
                ACT_ERASE:
                begin
                    cmd.seq       = SEQ_ERASE;
                    cmd.offset    = offset;
                    poll_off_next = offset;
                    phase_next    = PH_FIRST;
                end
                ACT_AUTOSEL: cmd.seq = SEQ_AUTOSEL;
                ACT_CFI:     cmd.seq = SEQ_CFI;
                ACT_RESET:   cmd.seq = SEQ_RESET;
                ACT_READ:
                begin
                    cmd.seq    = SEQ_READ;
                    cmd.offset = offset;
                end
                default:     cmd.seq = SEQ_REFUSE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            toggle_reg   <= 1'b0;
            poll_off_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            toggle_reg   <= toggle_next;
            poll_off_reg <= poll_off_next;
        end
    end

endmodule : nfcs_front
`default_nettype wire

FILE: hw/rtl/nfcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash command sequencer command queue
// Short register FIFO of command descriptors between the front and the back.
// ----------------------------------------------------------------------------
module nfcs_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire nfcs_pkg::cmd_t push_cmd,
    input  wire logic     pop,
    output nfcs_pkg::cmd_t head,
    output nfcs_pkg::qstat_t stat
);
    import nfcs_pkg::*;

    cmd_t                entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entries are cleared so that the head decodes cleanly while empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QDEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : nfcs_queue
`default_nettype wire

FILE: hw/rtl/nfcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash command sequencer back end
// Expands the command at the queue head into bus cycles, one per clock while
// out_stall is low, through a registered result stage.
// ----------------------------------------------------------------------------
module nfcs_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire nfcs_pkg::cmd_t               head,
    input  wire logic                         head_valid,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [nfcs_pkg::KIND_W-1:0]       cycle_kind,
    output logic [nfcs_pkg::OFF_W-1:0]        word_offset,
    output logic [nfcs_pkg::DATA_W-1:0]       bus_data,
    output logic                              last
);
    import nfcs_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [STEP_W-1:0]  seq_len;
    logic               step_last;
    logic               load;
    kind_t              item_kind;
    logic [OFF_W-1:0]   item_off;
    logic [DATA_W-1:0]  item_data;

    logic               valid_reg;
    logic               valid_next;
    kind_t              kind_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [DATA_W-1:0]  data_reg;
    logic               last_reg;

    always_comb
    begin
        unique case (head.seq)
            SEQ_PROGRAM: seq_len = 3'd5;
            SEQ_ERASE:   seq_len = 3'd7;
            SEQ_AUTOSEL: seq_len = 3'd3;
            SEQ_CFI:     seq_len = 3'd3;
            SEQ_RESET:   seq_len = 3'd1;
            SEQ_READ:    seq_len = 3'd1;
            SEQ_DONE:    seq_len = 3'd1;
            SEQ_REFUSE:  seq_len = 3'd1;
        endcase
    end

    // Bus cycle for the current step of the head command.
    always_comb
    begin
        item_kind = KIND_WRITE;
        item_off  = ADDR_UNLOCK1;
        item_data = '0;
        unique case (head.seq)
            SEQ_PROGRAM:
            begin
                unique case (step_reg)
                    3'd0:    item_data = CMD_UNLOCK1;
                    3'd1:
                    begin
                        item_off  = ADDR_UNLOCK2;
                        item_data = CMD_UNLOCK2;
                    end
                    3'd2:    item_data = CMD_PROGRAM;
                    3'd3:
                    begin
                        item_off  = head.offset;
                        item_data = head.data;
                    end
                    default:
                    begin
                        item_kind = KIND_READ;
                        item_off  = head.offset;
                    end
                endcase
            end
            SEQ_ERASE:
            begin
                unique case (step_reg)
                    3'd0:    item_data = CMD_UNLOCK1;
                    3'd1:
                    begin
                        item_off  = ADDR_UNLOCK2;
                        item_data = CMD_UNLOCK2;
                    end
                    3'd2:    item_data = CMD_ERASE;
                    3'd3:    item_data = CMD_UNLOCK1;
                    3'd4:
                    begin
                        item_off  = ADDR_UNLOCK2;
                        item_data = CMD_UNLOCK2;
                    end
                    3'd5:
                    begin
                        item_off  = head.offset;
                        item_data = CMD_SECTOR;
                    end
                    default:
                    begin
                        item_kind = KIND_READ;
                        item_off  = head.offset;
                    end
                endcase
            end
            SEQ_AUTOSEL, SEQ_CFI:
            begin
                unique case (step_reg)
                    3'd0:    item_data = CMD_UNLOCK1;
                    3'd1:
                    begin
                        item_off  = ADDR_UNLOCK2;
                        item_data = CMD_UNLOCK2;
                    end
                    default: item_data = (head.seq == SEQ_CFI) ? CMD_CFI : CMD_AUTOSEL;
                endcase
            end
            SEQ_RESET:
            begin
                item_off  = ADDR_ZERO;
                item_data = CMD_RESET;
            end
            SEQ_READ:
            begin
                item_kind = KIND_READ;
                item_off  = head.offset;
            end
            SEQ_DONE:
            begin
                item_kind = KIND_DONE;
                item_off  = head.offset;
            end
            SEQ_REFUSE:
            begin
                item_kind = KIND_REFUSE;
                item_off  = ADDR_ZERO;
            end
        endcase
    end

    // The result register refills from a waiting head when empty or being taken.
    assign load      = head_valid && (!valid_reg || !out_stall);
    assign step_last = (step_reg == seq_len - 3'd1);
    assign pop       = load && step_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = step_last ? '0 : step_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= item_kind;
            off_reg  <= item_off;
            data_reg <= item_data;
            last_reg <= step_last;
        end
    end

    assign out_valid   = valid_reg;
    assign cycle_kind  = kind_reg;
    assign word_offset = off_reg;
    assign bus_data    = data_reg;
    assign last        = last_reg;

endmodule : nfcs_back
`default_nettype wire

FILE: hw/rtl/nor_flash_command_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NOR flash command sequencer
// Turns flash requests into JEDEC unlock command runs and DQ6 toggle polling.
// ----------------------------------------------------------------------------
// An input item is accepted and classified at once; its command waits in a
// four-entry queue while the back end emits its bus cycles, one result item
// per clock while out_stall is low. A request yields as many result items as
// its sequence has steps: seven for sector erase, five for program, three for
// autoselect or CFI query, one for everything else. The back end's single
// result register sets the sustained rate of one result item per clock; the
// front keeps taking items until the queue is full, which drives in_stall.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer #(
    parameter int ADDR_BITS = 22
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [2:0]                   action,
    input  wire logic [ADDR_BITS-1:0]         byte_address,
    input  wire logic [nfcs_pkg::DATA_W-1:0]  data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [nfcs_pkg::KIND_W-1:0]       cycle_kind,
    output logic [nfcs_pkg::OFF_W-1:0]        word_offset,
    output logic [nfcs_pkg::DATA_W-1:0]       bus_data,
    output logic                              last
);
    import nfcs_pkg::*;

    logic [ADDR_BITS+OFF_W-1:0] addr_ext;
    logic [OFF_W-1:0]           in_offset;
    logic                       accept;
    cmd_t                       front_cmd;
    cmd_t                       head_cmd;
    qstat_t                     qstat;
    logic                       pop;

    // Word offset is the byte address shifted right by one, zero-extended
    // or truncated to the bus offset width.
    assign addr_ext  = {{OFF_W{1'b0}}, byte_address};
    assign in_offset = addr_ext[OFF_W:1];

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    nfcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .action (action),
        .offset (in_offset),
        .data   (data),
        .cmd    (front_cmd)
    );

    nfcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .stat     (qstat)
    );

    nfcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .head_valid  (!qstat.empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cycle_kind  (cycle_kind),
        .word_offset (word_offset),
        .bus_data    (bus_data),
        .last        (last)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("command queue count beyond its depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("command popped from an empty queue");

    a_refuse_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_kind == KIND_REFUSE) |-> (last && word_offset == '0))
        else $error("refused result is not a single item at offset zero");

    a_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_kind != KIND_WRITE) |-> (bus_data == '0))
        else $error("bus data nonzero on a result that is not a write");

endmodule : nor_flash_command_sequencer
`default_nettype wire
